[sv/meiq_pkg.sv]
`default_nettype none

package meiq_pkg;

   localparam int unsigned MAIN_DEPTH_DEF  = 256;
   localparam int unsigned SYSEX_DEPTH_DEF = 256;

   localparam int unsigned WORD_W  = 32;
   localparam int unsigned STAMP_W = 32;
   localparam int unsigned ACT_W   = 3;
   localparam int unsigned FILL_W  = 8;
   localparam int unsigned OWNER_W = 5;

   localparam logic [FILL_W-1:0] FILL_MAX = 8'hFF;

   localparam logic [ACT_W-1:0] ACT_ROUTED     = 3'd0;
   localparam logic [ACT_W-1:0] ACT_DIRECT     = 3'd1;
   localparam logic [ACT_W-1:0] ACT_READ_MAIN  = 3'd2;
   localparam logic [ACT_W-1:0] ACT_READ_SYSEX = 3'd3;
   localparam logic [ACT_W-1:0] ACT_FLUSH_MAIN = 3'd4;
   localparam logic [ACT_W-1:0] ACT_FLUSH_SX   = 3'd5;

   localparam logic [3:0] CIN_SX_START = 4'd4;
   localparam logic [3:0] CIN_SX_END_1 = 4'd5;
   localparam logic [3:0] CIN_SX_END_3 = 4'd7;

   localparam logic [OWNER_W-1:0] OWNER_FREE = 5'd16;

   localparam logic [WORD_W-1:0] NOTEON_MASK = 32'hFF00F00F;
   localparam logic [WORD_W-1:0] NOTEON_ZERO = 32'h00009009;
   localparam logic [WORD_W-1:0] NOTEOFF_AND = 32'hFFFFEFFE;

   typedef struct packed {
      logic push;
      logic pop;
      logic flush;
   } ring_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } ring_status_type;

endpackage

`default_nettype wire

[sv/meiq_ring.sv]
`default_nettype none

module meiq_ring
   import meiq_pkg::*;
#(
   parameter int unsigned DEPTH  = MAIN_DEPTH_DEF,
   parameter int unsigned DATA_W = WORD_W
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire ring_cmd_type        cmd,
   input  wire logic [DATA_W-1:0]   wdata,
   output ring_status_type          status,
   output logic      [DATA_W-1:0]   rdata,
   output logic      [FILL_W-1:0]   fill
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [PTR_W:0]   DEPTH_EXT = (PTR_W + 1)'(DEPTH);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [PTR_W-1:0]  tail_ff, tail_in;
   logic [PTR_W-1:0]  head_nx, tail_nx;
   logic [PTR_W:0]    diff;

   assign head_nx = (head_ff == LAST_PTR) ? '0 : head_ff + 1'b1;
   assign tail_nx = (tail_ff == LAST_PTR) ? '0 : tail_ff + 1'b1;

   assign status.empty = (head_ff == tail_ff);
   assign status.full  = (head_nx == tail_ff);

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      if (cmd.flush) begin
         head_in = '0;
         tail_in = '0;
      end else begin
         if (cmd.push && !status.full) begin
            head_in = head_nx;
         end
         if (cmd.pop && !status.empty) begin
            tail_in = tail_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push && !status.full && !cmd.flush) begin
         mem[head_ff] <= wdata;
      end
      if (cmd.pop) begin
         rdata_ff <= mem[tail_ff];
      end
   end

   assign rdata = rdata_ff;

   always_comb begin
      if (head_ff >= tail_ff) begin
         diff = {1'b0, head_ff} - {1'b0, tail_ff};
      end else begin
         diff = {1'b0, head_ff} + DEPTH_EXT - {1'b0, tail_ff};
      end
      fill = (32'(diff) > 32'(FILL_MAX)) ? FILL_MAX : FILL_W'(diff);
   end

endmodule

`default_nettype wire

[sv/midi_event_input_queues.sv]
// A word accepted on start gives its result with rsp_strobe in the next cycle.
// Throughput: one word per cycle; busy stays low, as each ring does one
// memory access per word and read data is registered at the ring's read port.
// Reset: synchronous, active high; empties both rings and unlocks the SysEx ring.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

module midi_event_input_queues
   import meiq_pkg::*;
#(
   parameter int unsigned MAIN_DEPTH  = MAIN_DEPTH_DEF,
   parameter int unsigned SYSEX_DEPTH = SYSEX_DEPTH_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic [ACT_W-1:0]     req_action,
   input  wire logic [WORD_W-1:0]    req_packet,
   input  wire logic [STAMP_W-1:0]   req_stamp,
   output logic                      rsp_strobe,
   output logic                      rsp_ok,
   output logic      [WORD_W-1:0]    rsp_out_packet,
   output logic      [STAMP_W-1:0]   rsp_out_stamp,
   output logic      [FILL_W-1:0]    rsp_main_fill,
   output logic      [FILL_W-1:0]    rsp_sysex_fill
);

   ring_cmd_type    main_cmd, sx_cmd;
   ring_status_type main_st, sx_st;
   logic [WORD_W+STAMP_W-1:0] main_rdata;
   logic [WORD_W-1:0]         sx_rdata;
   logic [WORD_W-1:0]         main_word;
   logic [WORD_W-1:0]         conv_packet;
   logic                      accept;
   logic [3:0]                cin;
   logic [3:0]                cable;
   logic                      is_sx;
   logic                      lock_ok;
   logic                      ok_in;
   logic [OWNER_W-1:0]        owner_ff, owner_in;
   logic                      strobe_ff;
   logic                      ok_ff;
   logic                      sel_main_ff, sel_main_in;
   logic                      sel_sx_ff, sel_sx_in;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign cin     = req_packet[3:0];
   assign cable   = req_packet[7:4];
   assign is_sx   = (cin >= CIN_SX_START) && (cin <= CIN_SX_END_3);
   assign lock_ok = (owner_ff == OWNER_FREE) || (owner_ff == {1'b0, cable});

   assign conv_packet = ((req_packet & NOTEON_MASK) == NOTEON_ZERO) ?
                        (req_packet & NOTEOFF_AND) : req_packet;

   always_comb begin
      main_cmd    = '0;
      sx_cmd      = '0;
      main_word   = req_packet;
      owner_in    = owner_ff;
      ok_in       = 1'b0;
      sel_main_in = 1'b0;
      sel_sx_in   = 1'b0;
      if (accept) begin
         unique case (req_action)
            ACT_ROUTED: begin
               if (is_sx) begin
                  if (lock_ok) begin
                     owner_in    = {1'b0, cable};
                     sx_cmd.push = 1'b1;
                     ok_in       = !sx_st.full;
                     if (!sx_st.full && (cin >= CIN_SX_END_1)) begin
                        owner_in = OWNER_FREE;
                     end
                  end
               end else begin
                  main_word     = conv_packet;
                  main_cmd.push = 1'b1;
                  ok_in         = !main_st.full;
               end
            end
            ACT_DIRECT: begin
               main_cmd.push = 1'b1;
               ok_in         = !main_st.full;
            end
            ACT_READ_MAIN: begin
               main_cmd.pop = 1'b1;
               ok_in        = !main_st.empty;
               sel_main_in  = !main_st.empty;
            end
            ACT_READ_SYSEX: begin
               sx_cmd.pop = 1'b1;
               ok_in      = !sx_st.empty;
               sel_sx_in  = !sx_st.empty;
            end
            ACT_FLUSH_MAIN: begin
               main_cmd.flush = 1'b1;
               ok_in          = 1'b1;
            end
            ACT_FLUSH_SX: begin
               sx_cmd.flush = 1'b1;
               owner_in     = OWNER_FREE;
               ok_in        = 1'b1;
            end
            default: begin
               ok_in = 1'b0;
            end
         endcase
      end
   end

   meiq_ring #(
      .DEPTH  (MAIN_DEPTH),
      .DATA_W (WORD_W + STAMP_W)
   ) u_main_ring (
      .clock  (clock),
      .reset  (reset),
      .cmd    (main_cmd),
      .wdata  ({req_stamp, main_word}),
      .status (main_st),
      .rdata  (main_rdata),
      .fill   (rsp_main_fill)
   );

   meiq_ring #(
      .DEPTH  (SYSEX_DEPTH),
      .DATA_W (WORD_W)
   ) u_sx_ring (
      .clock  (clock),
      .reset  (reset),
      .cmd    (sx_cmd),
      .wdata  (req_packet),
      .status (sx_st),
      .rdata  (sx_rdata),
      .fill   (rsp_sysex_fill)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         owner_ff    <= OWNER_FREE;
         strobe_ff   <= 1'b0;
         ok_ff       <= 1'b0;
         sel_main_ff <= 1'b0;
         sel_sx_ff   <= 1'b0;
      end else begin
         owner_ff    <= owner_in;
         strobe_ff   <= accept;
         ok_ff       <= ok_in;
         sel_main_ff <= sel_main_in;
         sel_sx_ff   <= sel_sx_in;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_ok     = ok_ff;

   always_comb begin
      rsp_out_packet = '0;
      rsp_out_stamp  = '0;
      if (sel_main_ff) begin
         rsp_out_packet = main_rdata[WORD_W-1:0];
         rsp_out_stamp  = main_rdata[WORD_W+STAMP_W-1:WORD_W];
      end else if (sel_sx_ff) begin
         rsp_out_packet = sx_rdata;
      end
   end

endmodule

`default_nettype wire
